FILE: design/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and constants of the binary heap priority queue
// Entry layout, status and command codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package bhpq_pkg;

   localparam int CAPACITY  = 256;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int ENTRY_W   = 40;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [0:0] REG_KEY_SELECT = 1'd0;

   typedef struct packed {
      logic [15:0] pid;
      logic [15:0] burst;
      logic [7:0]  prio;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,     // read parent
      ST_UP_CMP,    // compare with parent
      ST_DN_LAST,   // read last entry
      ST_DN_MOVE,   // last entry goes to root
      ST_DN_RD,     // read children
      ST_DN_CMP,    // pick child, compare
      ST_TOP_RD,    // read root
      ST_TOP_WAIT,
      ST_DONE
   } state_type;

   // true if a orders strictly before b
   function automatic logic goes_before(entry_type a, entry_type b, logic ksel);
      logic [15:0] ka;
      logic [15:0] kb;
      ka = ksel ? {8'd0, a.prio} : a.burst;
      kb = ksel ? {8'd0, b.prio} : b.burst;
      if (ka != kb) return ka < kb;
      return a.pid < b.pid;
   endfunction

endpackage
`default_nettype wire

FILE: design/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min-heap of process entries in two-port synchronous RAM, sifted by a
// sequencer one level per step.
// ----------------------------------------------------------------------------
// Throughput: one beat at a time; a new request waits until the result beat is
//   taken. Each sift level reads the parent (insert) or both children (remove),
//   compares, and writes the swapped pair back to the heap RAM.
// Reset: synchronous, clears count, key select and control; RAM not cleared.
`default_nettype none
module binary_heap_priority_queue
   import bhpq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_proc_id,
   input  wire logic [15:0] req_burst_len,
   input  wire logic [7:0]  req_prio_level,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_top_valid,
   output logic [15:0]      rsp_top_proc_id,
   output logic [15:0]      rsp_top_burst_len,
   output logic [7:0]       rsp_top_prio_level,
   output logic [8:0]       rsp_entry_count,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // heap RAM, two ports
   entry_type heap_mem [CAPACITY];

   state_type         state_ff, state_in;
   logic              ksel_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;      // current slot
   entry_type         cur_ff, cur_in;      // entry being sifted
   logic [1:0]        stat_ff, stat_in;
   logic              out_valid_ff;

   logic              wa_en, wb_en;
   logic [IDX_W-1:0]  wa_addr, wb_addr, ra_addr, rb_addr;
   entry_type         wa_data, wb_data;
   entry_type         ra_q, rb_q;

   // per-step helpers
   logic [IDX_W-1:0]  parent_idx;
   logic [CNT_W:0]    left_w, right_w;
   logic              left_ok, right_ok, pick_right;
   entry_type         pick_e;
   logic [IDX_W-1:0]  pick_idx;
   logic              rsp_take;

   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign left_w     = {1'b0, idx_ff, 1'b1};
   assign right_w    = left_w + (CNT_W+1)'(1);
   assign left_ok    = left_w  < {1'b0, count_ff};
   assign right_ok   = right_w < {1'b0, count_ff};
   assign pick_right = right_ok && !goes_before(ra_q, rb_q, ksel_ff);
   assign pick_e     = pick_right ? rb_q : ra_q;
   assign pick_idx   = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
   assign rsp_take   = rsp_valid && rsp_ready;

   // RAM ports
   always_ff @(posedge clock) begin
      if (wa_en) heap_mem[wa_addr] <= wa_data;
      if (wb_en) heap_mem[wb_addr] <= wb_data;
      ra_q <= heap_mem[ra_addr];
      rb_q <= heap_mem[rb_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) state_in = ST_TOP_RD;
                  else if (count_ff == '0)          state_in = ST_TOP_RD;
                  else                              state_in = ST_UP_RD;
               end else begin
                  if (count_ff <= CNT_W'(1)) state_in = ST_TOP_RD;
                  else                       state_in = ST_DN_LAST;
               end
            end
         end
         ST_UP_RD:  state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            if (goes_before(cur_ff, ra_q, ksel_ff) && parent_idx != '0)
               state_in = ST_UP_RD;
            else
               state_in = ST_TOP_RD;
         end
         ST_DN_LAST: state_in = ST_DN_MOVE;
         // root has a left child only with two or more entries left
         ST_DN_MOVE: state_in = (count_ff > CNT_W'(1)) ? ST_DN_RD : ST_TOP_RD;
         ST_DN_RD:   state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (goes_before(pick_e, cur_ff, ksel_ff) &&
                ({1'b0, pick_idx, 1'b1} < {1'b0, count_ff}))
               state_in = ST_DN_RD;
            else
               state_in = ST_TOP_RD;
         end
         ST_TOP_RD:   state_in = ST_TOP_WAIT;
         ST_TOP_WAIT: state_in = ST_DONE;
         ST_DONE:     state_in = rsp_take ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      stat_in  = stat_ff;
      wa_en = 1'b0; wa_addr = idx_ff; wa_data = cur_ff;
      wb_en = 1'b0; wb_addr = idx_ff; wb_data = cur_ff;
      ra_addr = '0; rb_addr = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cur_in  = '{pid: req_proc_id, burst: req_burst_len, prio: req_prio_level};
            stat_in = STATUS_OK;
            if (req_valid) begin
               if (req_cmd == CMD_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     stat_in = STATUS_FULL;
                  end else begin
                     // new entry at the tail slot
                     idx_in   = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     wa_en    = 1'b1;
                     wa_addr  = count_ff[IDX_W-1:0];
                     wa_data  = cur_in;
                  end
               end else begin
                  if (count_ff == '0) stat_in = STATUS_EMPTY;
                  else                count_in = count_ff - CNT_W'(1);
               end
            end
         end
         ST_UP_RD: ra_addr = parent_idx;
         ST_UP_CMP: begin
            if (goes_before(cur_ff, ra_q, ksel_ff)) begin
               // swap with parent
               wa_en = 1'b1; wa_addr = parent_idx; wa_data = cur_ff;
               wb_en = 1'b1; wb_addr = idx_ff;     wb_data = ra_q;
               idx_in = parent_idx;
            end
         end
         ST_DN_LAST: ra_addr = count_ff[IDX_W-1:0];
         ST_DN_MOVE: begin
            cur_in = ra_q;
            idx_in = '0;
            wa_en = 1'b1; wa_addr = '0; wa_data = ra_q;
         end
         ST_DN_RD: begin
            ra_addr = left_w[IDX_W-1:0];
            rb_addr = right_w[IDX_W-1:0];
         end
         ST_DN_CMP: begin
            if (goes_before(pick_e, cur_ff, ksel_ff)) begin
               wa_en = 1'b1; wa_addr = pick_idx; wa_data = cur_ff;
               wb_en = 1'b1; wb_addr = idx_ff;   wb_data = pick_e;
               idx_in = pick_idx;
            end
         end
         ST_TOP_RD:   ra_addr = '0;
         ST_TOP_WAIT: begin
            cur_in = ra_q;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ksel_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= (state_in == ST_DONE);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == REG_KEY_SELECT)
            ksel_ff <= csr_pwdata[0];
      end
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
      stat_ff <= stat_in;
   end

   // result beat
   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = stat_ff;
   assign rsp_top_valid      = (count_ff != '0);
   assign rsp_top_proc_id    = rsp_top_valid ? cur_ff.pid   : 16'd0;
   assign rsp_top_burst_len  = rsp_top_valid ? cur_ff.burst : 16'd0;
   assign rsp_top_prio_level = rsp_top_valid ? cur_ff.prio  : 8'd0;
   assign rsp_entry_count    = 9'(count_ff);

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_KEY_SELECT) ? {31'd0, ksel_ff} : 32'd0;

endmodule
`default_nettype wire

FILE: design/bhpq_checker.sv
// ----------------------------------------------------------------------------
// bhpq_checker: port-level checks of the heap queue
// Watches handshakes and count bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none
module bhpq_checker
   import bhpq_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_top_valid,
   input wire logic [8:0] rsp_entry_count
);

   // a result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("result beat dropped");

   // one item at a time: no accept while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted with result pending");

   // top valid follows count
   a_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_top_valid == (rsp_entry_count != 9'd0)))
      else $error("top valid mismatch");

   // empty status only with empty heap
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_entry_count == 9'd0)
      else $error("empty status with entries");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_top_valid(rsp_top_valid), .rsp_entry_count(rsp_entry_count)
);
`default_nettype wire
